// ===== sv/lus_pkg.sv =====
// Shared constants and types for the largest uniform square scan block.
`default_nettype none

package lus_pkg;

    // Fixed field widths
    localparam int CHAR_W       = 8;
    localparam int CFG_W        = 9;
    localparam int OUT_SIZE_W   = 9;
    localparam int OUT_POS_W    = 8;

    // Defaults
    localparam int MAX_SIDE_DEF = 256;
    localparam int SIDE_RESET   = 16;

    // Flags from the cell evaluator to the scan control
    typedef struct packed {
        logic match;    // cell extends a uniform square
        logic better;   // new size strictly beats the running best
    } t_eval_flags;

endpackage

`default_nettype wire

// ===== sv/lus_line_mem.sv =====
// Line buffer memory: one write port, one registered read port.
`default_nettype none

module lus_line_mem #(
    parameter int DEPTH  = lus_pkg::MAX_SIDE_DEF,
    parameter int ADDR_W = $clog2(lus_pkg::MAX_SIDE_DEF),
    parameter int DATA_W = lus_pkg::CHAR_W + lus_pkg::OUT_SIZE_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== sv/lus_cell_eval.sv =====
// Cell evaluator: neighbor match, minimum of three sizes plus one, best compare.
`default_nettype none

module lus_cell_eval #(
    parameter int SIZE_W = $clog2(lus_pkg::MAX_SIDE_DEF + 1)
) (
    input  wire logic [lus_pkg::CHAR_W-1:0] i_cell_char,
    input  wire logic [lus_pkg::CHAR_W-1:0] i_up_char,
    input  wire logic [SIZE_W-1:0]          i_up_size,
    input  wire logic [lus_pkg::CHAR_W-1:0] i_left_char,
    input  wire logic [SIZE_W-1:0]          i_left_size,
    input  wire logic [lus_pkg::CHAR_W-1:0] i_diag_char,
    input  wire logic [SIZE_W-1:0]          i_diag_size,
    input  wire logic                       i_edge,
    input  wire logic [SIZE_W-1:0]          i_best_size,
    output logic      [SIZE_W-1:0]          o_size,
    output lus_pkg::t_eval_flags            o_flags
);

    logic [SIZE_W-1:0] min_size;
    logic              match;

    always_comb begin
        match = !i_edge && (i_cell_char == i_up_char) &&
                (i_cell_char == i_left_char) && (i_cell_char == i_diag_char);

        // take the smallest of the three neighbor sizes
        min_size = i_up_size;
        if (i_left_size < min_size) begin
            min_size = i_left_size;
        end
        if (i_diag_size < min_size) begin
            min_size = i_diag_size;
        end

        o_size = match ? (min_size + SIZE_W'(1)) : SIZE_W'(1);

        o_flags.match  = match;
        o_flags.better = match && (o_size > i_best_size);
    end

endmodule

`default_nettype wire

// ===== sv/largest_uniform_square_scan.sv =====
// Top level of the largest uniform square scan block.
//
// Usage:
//  - Configuration channel (i_cfg_valid / o_cfg_ready, i_grid_side) sets the
//    grid side; 0 counts as 1 and values above MAX_SIDE saturate. A write
//    also restarts the scan. Write only while the block is idle.
//  - Input channel (i_valid / o_ready, i_cell_char) takes one grid cell per
//    item in raster order, one item per cycle when the result side is free.
//  - Output channel (o_valid / i_ready) carries one result per grid: size of
//    the largest uniform square and its bottom-right row and column.
//  - Result: registered; it shows in the cycle after the last cell is accepted.
//  - Throughput: one cell per cycle but for the stall below; the line buffer is
//    read one column ahead, so its registered read port costs no bubble.
//  - Stall: a waiting result blocks only the last cell of the next grid.
//  - Reset: side 16, scan at (0,0), best size 1, no result pending. The
//    line buffer needs no clearing: row 0 writes every column before use.
`default_nettype none

module largest_uniform_square_scan #(
    parameter int MAX_SIDE = lus_pkg::MAX_SIDE_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [lus_pkg::CFG_W-1:0]      i_grid_side,
    // cells in
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [lus_pkg::CHAR_W-1:0]     i_cell_char,
    // result out
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [lus_pkg::OUT_SIZE_W-1:0]      o_best_size,
    output logic [lus_pkg::OUT_POS_W-1:0]       o_best_row,
    output logic [lus_pkg::OUT_POS_W-1:0]       o_best_col
);

    localparam int POS_W      = $clog2(MAX_SIDE);
    localparam int SIZE_W     = $clog2(MAX_SIDE + 1);
    localparam int ENTRY_W    = lus_pkg::CHAR_W + SIZE_W;
    localparam int CMP_W      = (SIZE_W > lus_pkg::CFG_W) ? SIZE_W : lus_pkg::CFG_W;
    localparam int RESET_SIDE = (lus_pkg::SIDE_RESET > MAX_SIDE) ? MAX_SIDE
                                                                 : lus_pkg::SIDE_RESET;

    // scan state
    logic [SIZE_W-1:0]           r_side;
    logic [POS_W-1:0]            r_col, n_col;
    logic [POS_W-1:0]            r_row;
    logic [lus_pkg::CHAR_W-1:0]  r_left_char, r_diag_char;
    logic [SIZE_W-1:0]           r_left_size, r_diag_size;
    logic [SIZE_W-1:0]           r_best_size;
    logic [POS_W-1:0]            r_best_row, r_best_col;

    // result register
    logic                            r_out_valid;
    logic [lus_pkg::OUT_SIZE_W-1:0]  r_out_size;
    logic [lus_pkg::OUT_POS_W-1:0]   r_out_row, r_out_col;

    logic                       cfg_acc, in_acc, last_col, last_row, last_cell;
    logic [CMP_W-1:0]           cfg_ext;
    logic [SIZE_W-1:0]          cfg_side;
    logic [ENTRY_W-1:0]         up_entry;
    logic [lus_pkg::CHAR_W-1:0] up_char;
    logic [SIZE_W-1:0]          up_size;
    logic [SIZE_W-1:0]          cell_size;
    lus_pkg::t_eval_flags       flags;
    logic [SIZE_W-1:0]          fin_size;
    logic [POS_W-1:0]           fin_row, fin_col;

    // Clamp the written side into 1..MAX_SIDE.
    always_comb begin
        cfg_ext = CMP_W'(i_grid_side);
        if (cfg_ext == '0) begin
            cfg_side = SIZE_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_SIDE)) begin
            cfg_side = SIZE_W'(MAX_SIDE);
        end else begin
            cfg_side = SIZE_W'(cfg_ext);
        end
    end

    assign last_col  = (SIZE_W'(r_col) == (r_side - SIZE_W'(1)));
    assign last_row  = (SIZE_W'(r_row) == (r_side - SIZE_W'(1)));
    assign last_cell = last_col && last_row;

    // Hold off only the grid's last cell while an older result still waits.
    assign o_cfg_ready = 1'b1;
    assign o_ready     = !(last_cell && r_out_valid);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_valid && o_ready;

    // Next column drives the line buffer read, so the up neighbor of the next
    // cell is registered and waiting when that cell arrives.
    always_comb begin
        n_col = r_col;
        if (cfg_acc) begin
            n_col = '0;
        end else if (in_acc) begin
            n_col = last_col ? '0 : (r_col + POS_W'(1));
        end
    end

    lus_line_mem #(
        .DEPTH  (MAX_SIDE),
        .ADDR_W (POS_W),
        .DATA_W (ENTRY_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && !cfg_acc),
        .i_wr_addr (r_col),
        .i_wr_data ({i_cell_char, cell_size}),
        .i_rd_addr (n_col),
        .o_rd_data (up_entry)
    );

    assign up_char = up_entry[ENTRY_W-1 -: lus_pkg::CHAR_W];
    assign up_size = up_entry[SIZE_W-1:0];

    lus_cell_eval #(
        .SIZE_W (SIZE_W)
    ) u_cell_eval (
        .i_cell_char (i_cell_char),
        .i_up_char   (up_char),
        .i_up_size   (up_size),
        .i_left_char (r_left_char),
        .i_left_size (r_left_size),
        .i_diag_char (r_diag_char),
        .i_diag_size (r_diag_size),
        .i_edge      ((r_row == '0) || (r_col == '0)),
        .i_best_size (r_best_size),
        .o_size      (cell_size),
        .o_flags     (flags)
    );

    // Best including the current cell, for the result of the last cell.
    assign fin_size = flags.better ? cell_size : r_best_size;
    assign fin_row  = flags.better ? r_row : r_best_row;
    assign fin_col  = flags.better ? r_col : r_best_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side      <= SIZE_W'(RESET_SIDE);
            r_col       <= '0;
            r_row       <= '0;
            r_left_char <= '0;
            r_left_size <= '0;
            r_diag_char <= '0;
            r_diag_size <= '0;
            r_best_size <= SIZE_W'(1);
            r_best_row  <= '0;
            r_best_col  <= '0;
        end else if (cfg_acc) begin
            // new side: restart the scan
            r_side      <= cfg_side;
            r_col       <= '0;
            r_row       <= '0;
            r_left_char <= '0;
            r_left_size <= '0;
            r_diag_char <= '0;
            r_diag_size <= '0;
            r_best_size <= SIZE_W'(1);
            r_best_row  <= '0;
            r_best_col  <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            if (last_cell) begin
                // grid done: drop back to the start state
                r_row       <= '0;
                r_left_char <= '0;
                r_left_size <= '0;
                r_diag_char <= '0;
                r_diag_size <= '0;
                r_best_size <= SIZE_W'(1);
                r_best_row  <= '0;
                r_best_col  <= '0;
            end else begin
                if (last_col) begin
                    r_row <= r_row + POS_W'(1);
                end
                r_left_char <= i_cell_char;
                r_left_size <= cell_size;
                r_diag_char <= up_char;
                r_diag_size <= up_size;
                if (flags.better) begin
                    r_best_size <= cell_size;
                    r_best_row  <= r_row;
                    r_best_col  <= r_col;
                end
            end
        end
    end

    // Result register: set on the grid's last cell, clear when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && last_cell && !cfg_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && last_cell && !cfg_acc) begin
            r_out_size <= lus_pkg::OUT_SIZE_W'(fin_size);
            r_out_row  <= lus_pkg::OUT_POS_W'(fin_row);
            r_out_col  <= lus_pkg::OUT_POS_W'(fin_col);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_best_size = r_out_size;
    assign o_best_row  = r_out_row;
    assign o_best_col  = r_out_col;

`ifndef SYNTH
    // Scan position stays inside the configured grid.
    a_pos_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SIZE_W'(r_col) < r_side) && (SIZE_W'(r_row) < r_side))
        else $error("scan position outside grid");

    // Best size stays between one and the grid side.
    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best_size != '0) && (r_best_size <= r_side))
        else $error("best size out of range");

    // The last cell of a grid restarts the scan and raises the result.
    a_grid_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && last_cell && !cfg_acc) |=>
            (r_col == '0) && (r_row == '0) && (r_best_size == SIZE_W'(1)) && o_valid)
        else $error("grid end did not restart scan");

    // Input is held back only while a result is pending.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled without pending result");
`endif

endmodule

`default_nettype wire

// ===== tb/largest_uniform_square_scan_tb.sv =====
// Self-checking testbench for the largest uniform square scan block.
`timescale 1ns / 100ps

module largest_uniform_square_scan_tb;

    localparam int SIDE_LIMIT    = lus_pkg::MAX_SIDE_DEF;
    localparam int SETTLE_CYCLES = 4;      // result is registered, shows in the cycle after the last cell
    localparam int STALL_LIMIT   = 5000;   // cycles with no handshake on any channel

    // One result: size of the largest uniform square and its bottom-right cell
    typedef struct {
        logic [lus_pkg::OUT_SIZE_W-1:0] size;
        logic [lus_pkg::OUT_POS_W-1:0]  row;
        logic [lus_pkg::OUT_POS_W-1:0]  col;
    } t_square;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [lus_pkg::CFG_W-1:0]      i_grid_side = '0;
    logic                           i_valid     = 1'b0;
    logic                           o_ready;
    logic [lus_pkg::CHAR_W-1:0]     i_cell_char = '0;
    logic                           o_valid;
    logic                           i_ready     = 1'b0;
    logic [lus_pkg::OUT_SIZE_W-1:0] o_best_size;
    logic [lus_pkg::OUT_POS_W-1:0]  o_best_row;
    logic [lus_pkg::OUT_POS_W-1:0]  o_best_col;

    largest_uniform_square_scan i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_grid_side (i_grid_side),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cell_char (i_cell_char),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_best_size (o_best_size),
        .o_best_row  (o_best_row),
        .o_best_col  (o_best_col)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle rates in percent, changed between phases
    int send_idle_pct = 30;
    int recv_idle_pct = 75;
    int error_count   = 0;

    t_square expected_squares[$];

    // ------------------------------------------------------------------
    // Scan predictor: its own line buffers, neighbor registers and best
    // ------------------------------------------------------------------
    logic [lus_pkg::CHAR_W-1:0]     line_chars [SIDE_LIMIT];
    logic [lus_pkg::OUT_SIZE_W-1:0] line_sizes [SIDE_LIMIT];
    logic [lus_pkg::CHAR_W-1:0]     left_chr, diag_chr;
    logic [lus_pkg::OUT_SIZE_W-1:0] left_sz, diag_sz;
    int unsigned                    scan_row, scan_col;
    logic [lus_pkg::OUT_SIZE_W-1:0] best_sz;
    logic [lus_pkg::OUT_POS_W-1:0]  best_r, best_c;
    logic [lus_pkg::CFG_W-1:0]      side_reg = lus_pkg::CFG_W'(lus_pkg::SIDE_RESET);

    // Zero counts as one, anything above the line buffer depth saturates
    function automatic int unsigned active_side();
        if (side_reg == '0)
            return 1;
        if (side_reg > SIDE_LIMIT)
            return SIDE_LIMIT;
        return side_reg;
    endfunction

    task automatic restart_scan();
        left_chr = '0;
        left_sz  = '0;
        diag_chr = '0;
        diag_sz  = '0;
        scan_row = 0;
        scan_col = 0;
        best_sz  = lus_pkg::OUT_SIZE_W'(1);
        best_r   = '0;
        best_c   = '0;
    endtask

    task automatic load_side(input logic [lus_pkg::CFG_W-1:0] v);
        side_reg = v;
        restart_scan();
    endtask

    // Advance the scan by one cell; queue the result when the grid closes
    task automatic scan_cell(input logic [lus_pkg::CHAR_W-1:0] c);
        int unsigned                    side;
        int unsigned                    col;
        logic [lus_pkg::CHAR_W-1:0]     up_chr;
        logic [lus_pkg::OUT_SIZE_W-1:0] up_sz;
        logic [lus_pkg::OUT_SIZE_W-1:0] sz;
        t_square                        sq;
        side = active_side();
        if (scan_col >= side || scan_row >= side)
            restart_scan();
        col    = scan_col;
        up_chr = line_chars[col];
        up_sz  = line_sizes[col];
        if (scan_row != 0 && col != 0 && c == up_chr && c == left_chr && c == diag_chr) begin
            sz = up_sz;
            if (left_sz < sz)
                sz = left_sz;
            if (diag_sz < sz)
                sz = diag_sz;
            sz = sz + lus_pkg::OUT_SIZE_W'(1);
            // Only a strictly larger square moves the best
            if (sz > best_sz) begin
                best_sz = sz;
                best_r  = scan_row[lus_pkg::OUT_POS_W-1:0];
                best_c  = col[lus_pkg::OUT_POS_W-1:0];
            end
        end else begin
            sz = lus_pkg::OUT_SIZE_W'(1);
        end
        diag_chr        = up_chr;
        diag_sz         = up_sz;
        left_chr        = c;
        left_sz         = sz;
        line_chars[col] = c;
        line_sizes[col] = sz;
        if (col + 1 < side) begin
            scan_col = col + 1;
        end else begin
            scan_col = 0;
            if (scan_row + 1 < side) begin
                scan_row = scan_row + 1;
            end else begin
                sq.size = best_sz;
                sq.row  = best_r;
                sq.col  = best_c;
                expected_squares.push_back(sq);
                restart_scan();
            end
        end
    endtask

    initial begin
        restart_scan();
    end

    // ------------------------------------------------------------------
    // Result side: random stall, compare each result with the oldest
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_square sq;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_squares.size() == 0) begin
                report_mismatch("result with nothing pending, size", int'(o_best_size), 0);
            end else begin
                sq = expected_squares.pop_front();
                if (o_best_size !== sq.size)
                    report_mismatch("best_size", int'(o_best_size), int'(sq.size));
                if (o_best_row !== sq.row)
                    report_mismatch("best_row", int'(o_best_row), int'(sq.row));
                if (o_best_col !== sq.col)
                    report_mismatch("best_col", int'(o_best_col), int'(sq.col));
            end
        end
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge i_clk) begin
        int quiet_cycles;
        if (!i_rst_n || (i_valid && o_ready) || (i_cfg_valid && o_cfg_ready) ||
            (o_valid && i_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("largest_uniform_square_scan_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sending side
    // ------------------------------------------------------------------

    // Send one cell; valid stays high afterwards unless the next call idles
    task automatic send_cell(input logic [lus_pkg::CHAR_W-1:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cell_char <= c;
        do
            @(posedge i_clk);
        while (!o_ready);
        scan_cell(c);
    endtask

    // Drop valid, let every pending result drain, then settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_squares.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_side(input logic [lus_pkg::CFG_W-1:0] v);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_grid_side <= v;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        load_side(v);
    endtask

    // Send cells from one main character with scattered others;
    // per_mille sets how often the main character is used
    task automatic send_grid(input int cells, input int per_mille);
        logic [lus_pkg::CHAR_W-1:0] main_chr;
        logic [lus_pkg::CHAR_W-1:0] alt_chr;
        int                         r;
        main_chr = lus_pkg::CHAR_W'($urandom_range(0, 255));
        alt_chr  = lus_pkg::CHAR_W'($urandom_range(0, 255));
        for (int i = 0; i < cells; i++) begin
            r = $urandom_range(0, 999);
            if (r < per_mille)
                send_cell(main_chr);
            else if (r[0])
                send_cell(alt_chr);
            else
                send_cell(lus_pkg::CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Run one grid at the side that reset leaves
    task automatic test_default_side();
        send_grid(lus_pkg::SIDE_RESET * lus_pkg::SIDE_RESET, 900);
    endtask

    task automatic test_directed_cases();
        // Side zero acts as side one: every cell is a grid of its own
        write_side('0);
        send_cell(8'h00);
        send_cell(8'hFF);
        write_side(9'd1);
        send_cell(8'h5A);
        // Uniform 2x2 grid gives size two at the far corner
        write_side(9'd2);
        repeat (4) send_cell(8'hFF);
        // A differing last cell leaves the best at size one at the origin
        write_side(9'd2);
        repeat (3) send_cell(8'h00);
        send_cell(8'h01);
        // Abandon a grid halfway, then rewrite the side to restart the scan
        write_side(9'd3);
        repeat (4) send_cell(8'h00);
        write_side(9'd3);
        // Two equal squares: the first in raster order stays the best
        repeat (6) send_cell(8'hFF);
        repeat (3) send_cell(8'h00);
    endtask

    // Random sides and contents; some grids are cut short and restarted
    task automatic test_random_grids(input int quota);
        int sent;
        int side;
        int cells;
        int r;
        int per_mille;
        bit must_write;
        sent       = 0;
        must_write = 1'b1;
        while (sent < quota) begin
            if (must_write || $urandom_range(0, 99) < 60) begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    write_side('0);
                else if (r < 75)
                    write_side(lus_pkg::CFG_W'($urandom_range(1, 4)));
                else if (r < 95)
                    write_side(lus_pkg::CFG_W'($urandom_range(5, 8)));
                else
                    write_side(lus_pkg::CFG_W'($urandom_range(9, 16)));
            end
            side = active_side();
            cells = side * side;
            must_write = 1'b0;
            if ($urandom_range(0, 99) < 10) begin
                cells = $urandom_range(0, side * side - 1);
                must_write = 1'b1;
            end
            case ($urandom_range(0, 4))
                0: per_mille = 0;
                1: per_mille = 500;
                2: per_mille = 800;
                3: per_mille = 950;
                default: per_mille = 1000;
            endcase
            send_grid(cells, per_mille);
            sent += cells;
        end
    endtask

    // Widest side: a partial grid at the largest setting and at an oversized
    // setting that saturates to it, then a small grid checks the restart
    task automatic test_full_side();
        write_side(lus_pkg::CFG_W'(SIDE_LIMIT));
        send_grid(160, 1000);
        write_side('1);
        send_grid(64, 999);
        write_side(9'd4);
        send_grid(16, 1000);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles lightly, receiver stalls heavily
        send_idle_pct = 30;
        recv_idle_pct = 75;
        test_default_side();
        test_directed_cases();
        test_random_grids(100);

        // Swap the pressure
        send_idle_pct = 75;
        recv_idle_pct = 30;
        test_random_grids(100);

        // Full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_grids(100);
        test_full_side();

        wait_idle();
        if (error_count == 0 && expected_squares.size() == 0)
            $display("largest_uniform_square_scan_tb OK");
        else
            $display("largest_uniform_square_scan_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lus_pkg.sv
sv/lus_line_mem.sv
sv/lus_cell_eval.sv
sv/largest_uniform_square_scan.sv
tb/largest_uniform_square_scan_tb.sv
